### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### src/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg
// Shared widths, codes and types of the timed resource release block.
// ----------------------------------------------------------------------------
package trr_pkg;

    localparam int unsigned SLOT_COUNT = 256;
    localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned HOLD_W     = 9;

    localparam logic [COUNT_W-1:0] TOTAL_RESET = COUNT_W'(1024);

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [HOLD_W-1:0]  hold_t;

    typedef struct packed {
        logic   valid;
        logic   func;
        logic   hold_ok;
        count_t amount;
        count_t slot_sum;
        logic   booked;
    } trr_stage_t;

endpackage

### src/trr_if.sv
// ----------------------------------------------------------------------------
// trr_item_if / trr_result_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface trr_item_if;
    logic             valid;
    logic             ready;
    logic             func;
    trr_pkg::count_t  required_amount;
    trr_pkg::hold_t   hold_ticks;

    modport source (output valid, output func, output required_amount, output hold_ticks,
                    input ready);
    modport sink   (input valid, input func, input required_amount, input hold_ticks,
                    output ready);
endinterface

interface trr_result_if;
    logic             valid;
    logic             ready;
    trr_pkg::count_t  available_count;
    trr_pkg::count_t  freed_amount;
    logic             freed_valid;
    logic             overcommit;

    modport source (output valid, output available_count, output freed_amount,
                    output freed_valid, output overcommit, input ready);
    modport sink   (input valid, input available_count, input freed_amount,
                    input freed_valid, input overcommit, output ready);
endinterface

### src/timed_resource_release.sv
// ----------------------------------------------------------------------------
// timed_resource_release
// Resource pool with a 256-slot timing wheel for delayed release.
//
//   channel  dir  handshake        contents
//   item     in   valid/ready      func, required_amount, hold_ticks
//   result   out  valid/ready      available_count, freed_amount,
//                                  freed_valid, overcommit
//   cfg      in   cfg_wr_en        cfg_wr_data (pool size, reloads pool)
//
// One transaction per cycle while results are taken; an item passes the work
// stage register, then the result register. Slot read-modify-write uses a
// registered-read memory; a same-slot write forwards into the following read.
// Reset clears booked bits and wheel position, pool to 1024; no clearing pass.
// A stalled result holds the work stage, which in turn drops item ready.
// ----------------------------------------------------------------------------
module timed_resource_release (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  trr_pkg::count_t cfg_wr_data,
    trr_item_if.sink        item,
    trr_result_if.source    result
);
    import trr_pkg::*;

    trr_stage_t stage;
    logic       advance;
    logic       accept;

    assign item.ready = !stage.valid || advance;
    assign accept     = item.valid && item.ready;

    trr_wheel u_wheel (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_func   (item.func),
        .in_amount (item.required_amount),
        .in_hold   (item.hold_ticks),
        .advance   (advance),
        .stage     (stage)
    );

    trr_pool u_pool (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .stage           (stage),
        .out_ready       (result.ready),
        .advance         (advance),
        .out_valid       (result.valid),
        .available_count (result.available_count),
        .freed_amount    (result.freed_amount),
        .freed_valid     (result.freed_valid),
        .overcommit      (result.overcommit)
    );

endmodule

### src/trr_wheel.sv
// ----------------------------------------------------------------------------
// trr_wheel
// Timing wheel: slot address, slot memory, booked bits and the work stage
// register, with forwarding of a slot write to a read of the same slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trr_wheel (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                in_func,
    input  trr_pkg::count_t     in_amount,
    input  trr_pkg::hold_t      in_hold,
    input  logic                advance,
    output trr_pkg::trr_stage_t stage
);
    import trr_pkg::*;

    slot_t                 wheel_base_reg;
    slot_t                 wheel_base_next;
    slot_t                 rd_slot;
    logic                  hold_ok;
    logic                  s1_valid_reg;
    logic                  s1_func_reg;
    logic                  s1_ok_reg;
    slot_t                 s1_slot_reg;
    count_t                s1_amount_reg;
    count_t                rd_data_reg;
    count_t                slot_sum;
    count_t                wr_data;
    logic                  wr_en;
    logic                  clr_en;
    logic [SLOT_COUNT-1:0] booked_reg;
    count_t                slot_mem [SLOT_COUNT];

    assign hold_ok = (in_hold != '0) && (in_hold <= HOLD_W'(SLOT_COUNT));
    assign rd_slot = (in_func == FUNC_TICK) ? wheel_base_reg
                                            : wheel_base_reg + SLOT_W'(in_hold) - SLOT_W'(1);

    assign wheel_base_next = (accept && (in_func == FUNC_TICK)) ? wheel_base_reg + SLOT_W'(1)
                                                                : wheel_base_reg;

    assign slot_sum = booked_reg[s1_slot_reg] ? rd_data_reg : '0;
    assign wr_data  = slot_sum + s1_amount_reg;
    assign wr_en    = advance && (s1_func_reg == FUNC_ADD) && s1_ok_reg;
    assign clr_en   = advance && (s1_func_reg == FUNC_TICK);

    // slot memory with registered read; forward a same-edge write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[s1_slot_reg] <= wr_data;
        end
        if (accept)
        begin
            if (wr_en && (s1_slot_reg == rd_slot))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= slot_mem[rd_slot];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            booked_reg     <= '0;
            wheel_base_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            wheel_base_reg <= wheel_base_next;
            if (wr_en)
            begin
                booked_reg[s1_slot_reg] <= 1'b1;
            end
            else if (clr_en)
            begin
                booked_reg[s1_slot_reg] <= 1'b0;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= in_func;
            s1_ok_reg     <= hold_ok;
            s1_slot_reg   <= rd_slot;
            s1_amount_reg <= in_amount;
        end
    end

    assign stage.valid    = s1_valid_reg;
    assign stage.func     = s1_func_reg;
    assign stage.hold_ok  = s1_ok_reg;
    assign stage.amount   = s1_amount_reg;
    assign stage.slot_sum = slot_sum;
    assign stage.booked   = booked_reg[s1_slot_reg];

    `ASSERT_NEXT(a_accept_loads, accept, s1_valid_reg)
    `ASSERT_NEXT(a_stall_holds, s1_valid_reg && !advance && !accept,
                 s1_valid_reg && $stable(s1_slot_reg) && $stable(s1_func_reg))

endmodule

### src/trr_pool.sv
// ----------------------------------------------------------------------------
// trr_pool
// Pool count update, overcommit detection and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trr_pool (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  trr_pkg::count_t     cfg_wr_data,
    input  trr_pkg::trr_stage_t stage,
    input  logic                out_ready,
    output logic                advance,
    output logic                out_valid,
    output trr_pkg::count_t     available_count,
    output trr_pkg::count_t     freed_amount,
    output logic                freed_valid,
    output logic                overcommit
);
    import trr_pkg::*;

    count_t pool_count_reg;
    count_t pool_count_next;
    count_t result_pool;
    logic   add_ok;
    logic   released;
    logic   over;
    logic   out_valid_reg;
    count_t available_reg;
    count_t freed_amount_reg;
    logic   freed_valid_reg;
    logic   overcommit_reg;

    assign advance  = stage.valid && (!out_valid_reg || out_ready);
    assign add_ok   = (stage.func == FUNC_ADD) && stage.hold_ok;
    assign released = (stage.func == FUNC_TICK) && stage.booked;
    assign over     = add_ok && (stage.amount > pool_count_reg);

    always_comb
    begin
        priority if (add_ok)
        begin
            result_pool = pool_count_reg - stage.amount;
        end
        else if (released)
        begin
            result_pool = pool_count_reg + stage.slot_sum;
        end
        else
        begin
            result_pool = pool_count_reg;
        end
    end

    always_comb
    begin
        priority if (cfg_wr_en)
        begin
            pool_count_next = cfg_wr_data;
        end
        else if (advance)
        begin
            pool_count_next = result_pool;
        end
        else
        begin
            pool_count_next = pool_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_count_reg <= TOTAL_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pool_count_reg <= pool_count_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            available_reg    <= result_pool;
            freed_amount_reg <= released ? stage.slot_sum : '0;
            freed_valid_reg  <= released;
            overcommit_reg   <= over;
        end
    end

    assign out_valid       = out_valid_reg;
    assign available_count = available_reg;
    assign freed_amount    = freed_amount_reg;
    assign freed_valid     = freed_valid_reg;
    assign overcommit      = overcommit_reg;

    `ASSERT_NEXT(a_advance_fills, advance, out_valid_reg)
    `ASSERT_IMPL(a_over_not_freed, out_valid_reg && overcommit_reg, !freed_valid_reg)
    `ASSERT_IMPL(a_idle_tick_zero, out_valid_reg && !freed_valid_reg, freed_amount_reg == '0)

endmodule
